### src/pcs_64b66b_rx_decode_core_macros.svh
// Assertion macros for the 64b/66b receive decoder.
// Included by the top level; no other dependencies.
`ifndef PCS_64B66B_RX_DECODE_CORE_MACROS_SVH
`define PCS_64B66B_RX_DECODE_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PCSRX_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PCSRX_ASSERT(label, prop, msg) \
  `PCSRX_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### src/pcsrx_pkg.sv
// Shared types, block type codes and descrambler functions for the
// 64b/66b receive decoder. No dependencies.
package pcsrx_pkg;

  // Field and register widths.
  localparam int unsigned SyncW    = 2;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned HistW    = 58;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned AddrW    = 4;

  // Distance from the current bit to the near tap (x^39 term).
  localparam int unsigned TapNear  = 39;

  // Sync header value of a control block.
  localparam logic [SyncW-1:0] SyncCtrl = 2'd1;

  // Configuration register addresses.
  localparam logic [AddrW-1:0] AddrSeed = 4'd0;

  // Control block type codes.
  localparam logic [7:0] BtIdle       = 8'h1e;
  localparam logic [7:0] BtStartIdle  = 8'h33;
  localparam logic [7:0] BtStartLane0 = 8'h78;
  localparam logic [7:0] BtTerm0      = 8'h87;
  localparam logic [7:0] BtTerm1      = 8'h99;
  localparam logic [7:0] BtTerm2      = 8'haa;
  localparam logic [7:0] BtTerm3      = 8'hb4;
  localparam logic [7:0] BtTerm4      = 8'hcc;
  localparam logic [7:0] BtTerm5      = 8'hd2;
  localparam logic [7:0] BtTerm6      = 8'he1;
  localparam logic [7:0] BtTerm7      = 8'hff;

  // Descrambler history in stream order: bit 0 is the oldest received bit.
  typedef logic [HistW-1:0] hist_t;

  // One received block together with the history that precedes it.
  typedef struct packed {
    logic [SyncW-1:0]    blk_sync;
    logic [PayloadW-1:0] payload;
    hist_t               hist;
  } blk_t;

  // Input stage contents handed to the decoder.
  typedef struct packed {
    logic valid;
    blk_t blk;
  } stage_t;

  // One decoded result.
  typedef struct packed {
    logic [PayloadW-1:0] data_bytes;
    logic [CountW-1:0]   byte_count;
    logic [CountW-1:0]   idle_count;
    logic                frame_start;
    logic                frame_end;
    logic                unknown_type;
  } res_t;

  // The seed register holds the most recent bit in bit 0; the stored
  // history holds it in the top bit.
  function automatic hist_t bit_rev_hist(input hist_t v);
    hist_t r;
    for (int i = 0; i < HistW; i++) begin
      r[i] = v[HistW-1-i];
    end
    return r;
  endfunction

  // Self-synchronizing descrambler x^58 + x^39 + 1 over a whole block.
  function automatic logic [PayloadW-1:0] descramble(input logic [PayloadW-1:0] payload,
                                                     input hist_t prev);
    logic [PayloadW+HistW-1:0] ext;
    logic [PayloadW-1:0]       r;
    ext = {payload, prev};
    for (int i = 0; i < PayloadW; i++) begin
      r[i] = ext[i+HistW] ^ ext[i+HistW-TapNear] ^ ext[i];
    end
    return r;
  endfunction

  // Number of data bytes carried by a terminate block.
  function automatic logic [2:0] term_len(input logic [7:0] btype);
    logic [2:0] n;
    case (btype)
      BtTerm1: n = 3'd1;
      BtTerm2: n = 3'd2;
      BtTerm3: n = 3'd3;
      BtTerm4: n = 3'd4;
      BtTerm5: n = 3'd5;
      BtTerm6: n = 3'd6;
      BtTerm7: n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

### src/pcsrx_ifs.sv
// Valid/ready stream interfaces for received blocks and decoded results.
// Depends on pcsrx_pkg.
interface pcsrx_blk_if;
  import pcsrx_pkg::*;

  logic                valid;
  logic                ready;
  logic [SyncW-1:0]    blk_sync;
  logic [PayloadW-1:0] payload;

  modport source (output valid, blk_sync, payload, input ready);
  modport sink   (input valid, blk_sync, payload, output ready);
endinterface

interface pcsrx_res_if;
  import pcsrx_pkg::*;

  logic                valid;
  logic                ready;
  logic [PayloadW-1:0] data_bytes;
  logic [CountW-1:0]   byte_count;
  logic [CountW-1:0]   idle_count;
  logic                frame_start;
  logic                frame_end;
  logic                unknown_type;

  modport source (output valid, data_bytes, byte_count, idle_count, frame_start,
                  frame_end, unknown_type, input ready);
  modport sink   (input valid, data_bytes, byte_count, idle_count, frame_start,
                  frame_end, unknown_type, output ready);
endinterface

### src/pcs_64b66b_rx_decode_core.sv
// 64b/66b receive descrambler and block decoder, top level.
// Path: a block accepted into the input register is descrambled and decoded,
// then written into the result register once that register is free.
// Throughput: one block per cycle without output stalls; the input and
// result registers each hold one request, so output stalls back up one stage.
// Reset clears the seed register, the descrambler history and both valid bits.
`include "pcs_64b66b_rx_decode_core_macros.svh"

module pcs_64b66b_rx_decode_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pcsrx_blk_if.sink                     blk_i,
  pcsrx_res_if.source                   res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcsrx_pkg::AddrW-1:0]   paddr,
  input  logic [pcsrx_pkg::CfgDataW-1:0] pwdata,
  output logic [pcsrx_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import pcsrx_pkg::*;

  hist_t  seed_q;
  hist_t  hist;
  logic   seed_we;
  logic   adv;
  stage_t stage;

  // Configuration port: single seed register, no wait states.
  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr == AddrSeed);
  assign prdata  = (paddr == AddrSeed) ? {{(CfgDataW-HistW){1'b0}}, seed_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we) begin
      seed_q <= pwdata[HistW-1:0];
    end
  end

  pcsrx_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .blk_i     (blk_i),
    .seed_we_i (seed_we),
    .seed_i    (pwdata[HistW-1:0]),
    .adv_i     (adv),
    .stage_o   (stage),
    .hist_o    (hist)
  );

  pcsrx_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .adv_o   (adv),
    .res_o   (res_o)
  );

  // History follows the raw received bits of each accepted request.
  `PCSRX_ASSERT(a_hist_follows_rx, blk_i.valid && blk_i.ready && !seed_we |=> hist == $past(blk_i.payload[PayloadW-1:PayloadW-HistW]), "history did not take the received bits")
  // A seed write reloads the history in stream order.
  `PCSRX_ASSERT(a_seed_loads_hist, seed_we |=> hist == bit_rev_hist($past(pwdata[HistW-1:0])), "seed write did not load history")
  // An unrecognized type carries nothing else.
  `PCSRX_ASSERT(a_unknown_empty, res_o.valid && res_o.unknown_type |-> res_o.byte_count == 4'd0 && res_o.idle_count == 4'd0 && !res_o.frame_start && !res_o.frame_end, "unknown type with payload")
  // A block never both starts and ends a frame.
  `PCSRX_ASSERT(a_start_end_excl, res_o.valid |-> !(res_o.frame_start && res_o.frame_end), "start and end together")

endmodule

### src/pcsrx_in_stage.sv
// Input register and running descrambler history.
// Depends on pcsrx_pkg and pcsrx_blk_if.
module pcsrx_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcsrx_blk_if.sink          blk_i,
  input  logic               seed_we_i,
  input  pcsrx_pkg::hist_t   seed_i,
  input  logic               adv_i,
  output pcsrx_pkg::stage_t  stage_o,
  output pcsrx_pkg::hist_t   hist_o
);
  import pcsrx_pkg::*;

  logic  valid_q;
  blk_t  blk_q;
  hist_t hist_q;
  logic  accept;

  // The stage takes a new request when empty or when it is being drained.
  assign blk_i.ready = !valid_q || adv_i;
  assign accept      = blk_i.valid && blk_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the block with the history that precedes it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= '{blk_sync: blk_i.blk_sync, payload: blk_i.payload, hist: hist_q};
    end
  end

  // History is the last 58 received bits; a seed write reloads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (seed_we_i) begin
      hist_q <= bit_rev_hist(seed_i);
    end else if (accept) begin
      hist_q <= blk_i.payload[PayloadW-1:PayloadW-HistW];
    end
  end

  assign stage_o = '{valid: valid_q, blk: blk_q};
  assign hist_o  = hist_q;

endmodule

### src/pcsrx_decode.sv
// Descrambles a staged block, decodes its type and holds the result.
// Depends on pcsrx_pkg and pcsrx_res_if.
module pcsrx_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcsrx_pkg::stage_t stage_i,
  output logic              adv_o,
  pcsrx_res_if.source       res_o
);
  import pcsrx_pkg::*;

  logic                res_valid_q;
  res_t                res_q;
  res_t                res_d;
  logic                out_free;
  logic [PayloadW-1:0] plain;
  logic [7:0]          btype;
  logic [2:0]          tlen;

  // The result register frees up when empty or when its request is taken.
  assign out_free = !res_valid_q || res_o.ready;
  assign adv_o    = stage_i.valid && out_free;

  assign plain = descramble(stage_i.blk.payload, stage_i.blk.hist);
  assign btype = plain[7:0];
  assign tlen  = term_len(btype);

  // Block type decode.
  always_comb begin
    res_d = '0;
    if (stage_i.blk.blk_sync != SyncCtrl) begin
      res_d.data_bytes = plain;
      res_d.byte_count = 4'd8;
    end else begin
      unique case (btype) inside
        BtStartIdle: begin
          res_d.idle_count  = 4'd4;
          res_d.data_bytes  = {40'd0, plain[PayloadW-1:40]};
          res_d.byte_count  = 4'd3;
          res_d.frame_start = 1'b1;
        end
        BtStartLane0: begin
          res_d.data_bytes  = {8'd0, plain[PayloadW-1:8]};
          res_d.byte_count  = 4'd7;
          res_d.frame_start = 1'b1;
        end
        BtTerm0, BtTerm1, BtTerm2, BtTerm3, BtTerm4, BtTerm5, BtTerm6, BtTerm7: begin
          res_d.frame_end  = 1'b1;
          res_d.byte_count = {1'b0, tlen};
          for (int l = 0; l < 7; l++) begin
            if (3'(l) < tlen) begin
              res_d.data_bytes[8*l +: 8] = plain[8*l+8 +: 8];
            end
          end
        end
        BtIdle: begin
          res_d.idle_count = 4'd8;
        end
        default: begin
          res_d.unknown_type = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.data_bytes   = res_q.data_bytes;
  assign res_o.byte_count   = res_q.byte_count;
  assign res_o.idle_count   = res_q.idle_count;
  assign res_o.frame_start  = res_q.frame_start;
  assign res_o.frame_end    = res_q.frame_end;
  assign res_o.unknown_type = res_q.unknown_type;

endmodule
